// ----- src/aftg_pkg.sv -----
// ---------------------------------------------------------------------------
// aftg_pkg
// Shared types and constants for the ADC frame over-limit trip guard.
// ---------------------------------------------------------------------------
package aftg_pkg;

	// Limit on the violation counter; it saturates one above this value.
	localparam int MAX_VIOL     = 4;
	// Number of ADC channels held in the per-frame channel store.
	localparam int NUM_CHANNELS = 9;

	localparam int CNT_W    = $clog2(MAX_VIOL + 2);
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int CH_W      = 4;
	localparam int VALUE_W   = 12;
	localparam int DAC_CH_W  = 3;
	localparam int LEVEL_W   = 12;
	localparam int SLEVEL_W  = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;

	// Configuration register indices.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSE_CHANNEL    = 3'd0,
		REG_SENSE_LEVEL      = 3'd1,
		REG_TRIP_DAC_CHANNEL = 3'd2,
		REG_TRIP_DAC_VALUE   = 3'd3,
		REG_CURRENT_CHANNEL  = 3'd4,
		REG_CURRENT_LEVEL    = 3'd5,
		REG_BIAS_CHANNEL     = 3'd6,
		REG_BIAS_LEVEL       = 3'd7
	} cfg_reg_t;

	// Cause of a violation, in priority order; CAUSE_NONE means a clean frame.
	typedef enum logic [1:0] {
		CAUSE_CURRENT = 2'd0,
		CAUSE_BIAS    = 2'd1,
		CAUSE_SENSE   = 2'd2,
		CAUSE_NONE    = 2'd3
	} cause_t;

	typedef struct packed {
		logic [15:0] sample_word;
		logic        frame_end;
	} sample_t;

	typedef struct packed {
		logic [15:0] dac_command;
		logic        tripped;
		logic [1:0]  trip_cause;
	} result_t;

endpackage

// ----- src/adc_frame_overlimit_trip_guard.sv -----
// ---------------------------------------------------------------------------
// adc_frame_overlimit_trip_guard
// Collects one ADC readback value per channel over a frame and, at the end of
// the frame, checks the current, bias and user sense limits, counting
// consecutive violating frames and issuing a DAC trip command.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------
//  sample   | in        | sample_valid/sample_stall  | sample_t (word, end)
//  result   | out       | result_valid/result_stall  | result_t (cmd, trip, cause)
//  cfg      | in        | cfg_write                  | cfg_index, cfg_data
//
// One item per cycle is taken while no result is held under stall; an item is
// registered in the input register, and a frame end with a violation then
// yields a result in the result register. A single evaluation stage between
// the two registers runs the store update and limit compares.
// Reset clears the seen bits of the store, the counter, both valid flags and
// sets the configuration registers to their defaults. While a result waits
// under stall, an item in the input register is held there and sample_stall is raised.

module adc_frame_overlimit_trip_guard
	import aftg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [CH_W-1:0]     sense_channel_q;
	logic [SLEVEL_W-1:0] sense_level_q;
	logic [DAC_CH_W-1:0] trip_dac_channel_q;
	logic [VALUE_W-1:0]  trip_dac_value_q;
	logic [CH_W-1:0]     current_channel_q;
	logic [LEVEL_W-1:0]  current_level_q;
	logic [CH_W-1:0]     bias_channel_q;
	logic [LEVEL_W-1:0]  bias_level_q;

	// Pipeline and store state.
	logic                    valid_s1;
	sample_t                 item_s1;
	logic [NUM_CHANNELS-1:0] seen_q;
	logic [VALUE_W-1:0]      value_q [NUM_CHANNELS];
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	result_t                 out_q;

	// Evaluation signals.
	logic                    advance;
	logic [CH_W-1:0]         ch;
	logic [VALUE_W-1:0]      val;
	logic                    ch_ok;
	logic [NUM_CHANNELS-1:0] hit;
	logic [NUM_CHANNELS-1:0] over_cur;
	logic [NUM_CHANNELS-1:0] over_bias;
	logic [NUM_CHANNELS-1:0] over_sense;
	logic [VALUE_W-1:0]      eff_val [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] eff_seen;
	cause_t                  cause;
	logic [CNT_W-1:0]        next_count;
	logic                    trip;
	logic [15:0]             cmd;

	// Picks one channel's flag; a channel outside the store is never over.
	function automatic logic pick(input logic [NUM_CHANNELS-1:0] flags,
			input logic [CH_W-1:0] chan);
		logic ok;
		ok = ({1'b0, chan} < (CH_W+1)'(NUM_CHANNELS));
		return ok ? flags[chan[CH_IDX_W-1:0]] : 1'b0;
	endfunction

	// The evaluation stage moves on unless a result is still held by stall.
	assign advance      = valid_s1 && !(out_valid_q && result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_channel_q    <= CH_W'(0);
			sense_level_q      <= SLEVEL_W'(4100);
			trip_dac_channel_q <= DAC_CH_W'(2);
			trip_dac_value_q   <= VALUE_W'(0);
			current_channel_q  <= CH_W'(3);
			current_level_q    <= LEVEL_W'(60);
			bias_channel_q     <= CH_W'(2);
			bias_level_q       <= LEVEL_W'(1420);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SENSE_CHANNEL:    sense_channel_q    <= cfg_data[CH_W-1:0];
				REG_SENSE_LEVEL:      sense_level_q      <= cfg_data[SLEVEL_W-1:0];
				REG_TRIP_DAC_CHANNEL: trip_dac_channel_q <= cfg_data[DAC_CH_W-1:0];
				REG_TRIP_DAC_VALUE:   trip_dac_value_q   <= cfg_data[VALUE_W-1:0];
				REG_CURRENT_CHANNEL:  current_channel_q  <= cfg_data[CH_W-1:0];
				REG_CURRENT_LEVEL:    current_level_q    <= cfg_data[LEVEL_W-1:0];
				REG_BIAS_CHANNEL:     bias_channel_q     <= cfg_data[CH_W-1:0];
				REG_BIAS_LEVEL:       bias_level_q       <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			item_s1 <= sample;
		end
	end

	// Store as seen by this item: the current word fills an empty entry.
	always_comb begin
		ch    = item_s1.sample_word[15:12];
		val   = item_s1.sample_word[VALUE_W-1:0];
		ch_ok = ({1'b0, ch} < (CH_W+1)'(NUM_CHANNELS));
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			hit[i]        = ch_ok && (ch[CH_IDX_W-1:0] == CH_IDX_W'(i));
			eff_seen[i]   = seen_q[i] | hit[i];
			eff_val[i]    = seen_q[i] ? value_q[i] : val;
			over_cur[i]   = eff_seen[i] && (eff_val[i] > current_level_q);
			over_bias[i]  = eff_seen[i] && (eff_val[i] > bias_level_q);
			over_sense[i] = eff_seen[i] && ({1'b0, eff_val[i]} > sense_level_q);
		end
	end

	// Limit check in priority order, counter update and command word.
	always_comb begin
		if (pick(over_cur, current_channel_q)) begin
			cause = CAUSE_CURRENT;
		end else if (pick(over_bias, bias_channel_q)) begin
			cause = CAUSE_BIAS;
		end else if (pick(over_sense, sense_channel_q)) begin
			cause = CAUSE_SENSE;
		end else begin
			cause = CAUSE_NONE;
		end

		next_count = (count_q <= CNT_W'(MAX_VIOL)) ? count_q + CNT_W'(1) : count_q;
		trip       = (next_count > CNT_W'(MAX_VIOL));

		cmd = 16'h0000;
		if (trip) begin
			if (cause == CAUSE_SENSE) begin
				cmd = {1'b1, trip_dac_channel_q, trip_dac_value_q};
			end else begin
				cmd = {1'b1, bias_channel_q[DAC_CH_W-1:0], VALUE_W'(0)};
			end
		end
	end

	// Seen bits and the violation counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			if (item_s1.frame_end) begin
				seen_q  <= '0;
				count_q <= (cause == CAUSE_NONE) ? CNT_W'(0) : next_count;
			end else begin
				seen_q <= seen_q | hit;
			end
		end
	end

	// Channel values: only the first word on a channel in a frame is kept.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (advance && !item_s1.frame_end && hit[i] && !seen_q[i]) begin
				value_q[i] <= val;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.frame_end && (cause != CAUSE_NONE)) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.frame_end && (cause != CAUSE_NONE)) begin
			out_q.dac_command <= cmd;
			out_q.tripped     <= trip;
			out_q.trip_cause  <= cause;
		end
	end

endmodule

// ----- src/aftg_checker.sv -----
// ---------------------------------------------------------------------------
// aftg_checker
// Port-level checks for the ADC frame over-limit trip guard.
// ---------------------------------------------------------------------------
module aftg_checker
	import aftg_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_valid,
	input logic                 sample_stall,
	input sample_t              sample,
	input logic                 result_valid,
	input logic                 result_stall,
	input result_t              result,
	input logic                 cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	// The input side only backs up when a result is held by its consumer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("sample_stall raised without a stalled result");

	// No result is shown on the edge after one that sees reset asserted.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result_valid high during reset");

	// A stalled result stays and keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or was dropped");

	// A trip carries a DAC write; before a trip the word is all zero, and a
	// safety trip never writes a value.
	a_cmd_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.tripped
			? (result.dac_command[15] &&
				(result.trip_cause == CAUSE_SENSE || result.dac_command[11:0] == 12'h000))
			: (result.dac_command == 16'h0000)))
		else $error("malformed DAC command in result");

endmodule

bind adc_frame_overlimit_trip_guard aftg_checker u_aftg_checker (.*);

// ----- tb/adc_frame_overlimit_trip_guard_tb.sv -----
// ---------------------------------------------------------------------------
// adc_frame_overlimit_trip_guard_tb
// Self-checking bench for the ADC frame over-limit trip guard. A directed
// table covers the special cases under the reset settings. Random frames then
// run under several register settings, the all-zero and all-one ones among
// them. Each result is checked field by field against the directed table, or against
// an in-bench model of the channel store, the limit priority and the saturating violation counter.
// ---------------------------------------------------------------------------
module adc_frame_overlimit_trip_guard_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aftg_pkg::*;

	localparam int RUN_LIMIT    = 400000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 225;
	localparam int DRAIN_CYCLES = 6;
	localparam int NUM_REGS     = 8;
	localparam int SHOWN_FAILS  = 10;

	typedef struct packed {
		logic [15:0] word;
		logic        fin;
		logic        typed;
		result_t     res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Register copies held by the model, updated as each write lands.
	logic [3:0]  cfg_sense_ch, cfg_cur_ch, cfg_bias_ch;
	logic [12:0] cfg_sense_lvl;
	logic [2:0]  cfg_trip_ch;
	logic [11:0] cfg_trip_val, cfg_cur_lvl, cfg_bias_lvl;

	// Per-frame channel store and the violation counter of the model.
	bit          ch_seen [NUM_CHANNELS];
	logic [11:0] ch_value [NUM_CHANNELS];
	int          viol_cnt;

	result_t        awaited_q [$];
	logic [CFG_W-1:0] setting [NUM_REGS];
	int             send_idle_pct, stall_pct;
	int             fail_cnt, items_sent, frames_sent, n_results, n_trips;

	// Directed items under the reset settings: current on channel 3 above 60,
	// bias on channel 2 above 1420, sense on channel 0 above 4100.
	dir_row_t dir_tab [18] = '{
		'{16'h3FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_CURRENT}},
		'{16'h2FFF, 1'b0, 1'b0, '0},
		'{16'h2000, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_BIAS}},
		'{16'hFFFF, 1'b0, 1'b0, '0},
		'{16'h9FFF, 1'b1, 1'b0, '0},
		'{16'h303D, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_CURRENT}},
		'{16'h303C, 1'b1, 1'b0, '0},
		'{16'h3FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_CURRENT}},
		'{16'h3FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_CURRENT}},
		'{16'h3FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_CURRENT}},
		'{16'h3FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, CAUSE_CURRENT}},
		'{16'h2FFF, 1'b0, 1'b0, '0},
		'{16'h3FFF, 1'b1, 1'b1, '{16'hA000, 1'b1, CAUSE_CURRENT}},
		'{16'h2FFF, 1'b1, 1'b1, '{16'hA000, 1'b1, CAUSE_BIAS}},
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h8FFF, 1'b1, 1'b0, '0},
		'{16'h1FFF, 1'b1, 1'b0, '0},
		'{16'h0FFF, 1'b1, 1'b0, '0}
	};

	adc_frame_overlimit_trip_guard dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A checked channel counts only if it is in range and was seen this frame.
	function automatic bit channel_over(input logic [3:0] ch, input logic [12:0] lvl);
		if (ch >= NUM_CHANNELS)
			return 1'b0;
		return ch_seen[ch] && ({1'b0, ch_value[ch]} > lvl);
	endfunction

	// Updates the model with one item and returns 1 when it gives a result.
	function automatic bit guard_predict(input sample_t s, output result_t r);
		logic [3:0] ch;
		cause_t     cause;
		ch = s.sample_word[15:12];
		r = '0;
		if (ch < NUM_CHANNELS && !ch_seen[ch]) begin
			ch_seen[ch] = 1'b1;
			ch_value[ch] = s.sample_word[11:0];
		end
		if (!s.frame_end)
			return 1'b0;
		if (channel_over(cfg_cur_ch, {1'b0, cfg_cur_lvl}))
			cause = CAUSE_CURRENT;
		else if (channel_over(cfg_bias_ch, {1'b0, cfg_bias_lvl}))
			cause = CAUSE_BIAS;
		else if (channel_over(cfg_sense_ch, cfg_sense_lvl))
			cause = CAUSE_SENSE;
		else
			cause = CAUSE_NONE;
		foreach (ch_seen[i]) begin
			ch_seen[i] = 1'b0;
			ch_value[i] = '0;
		end
		if (cause == CAUSE_NONE) begin
			viol_cnt = 0;
			return 1'b0;
		end
		if (viol_cnt <= MAX_VIOL)
			viol_cnt++;
		r.tripped = (viol_cnt > MAX_VIOL);
		r.trip_cause = cause;
		if (r.tripped) begin
			if (cause == CAUSE_SENSE)
				r.dac_command = {1'b1, cfg_trip_ch, cfg_trip_val};
			else
				r.dac_command = {1'b1, cfg_bias_ch[2:0], 12'h000};
		end
		return 1'b1;
	endfunction

	task automatic report_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= SHOWN_FAILS)
			$display("%s", msg);
	endtask

	// Writes all registers back to back, keeping the write enable high.
	task automatic write_settings();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= setting[i];
			@(posedge clk);
			case (cfg_reg_t'(i))
				REG_SENSE_CHANNEL:    cfg_sense_ch = setting[i][3:0];
				REG_SENSE_LEVEL:      cfg_sense_lvl = setting[i][12:0];
				REG_TRIP_DAC_CHANNEL: cfg_trip_ch = setting[i][2:0];
				REG_TRIP_DAC_VALUE:   cfg_trip_val = setting[i][11:0];
				REG_CURRENT_CHANNEL:  cfg_cur_ch = setting[i][3:0];
				REG_CURRENT_LEVEL:    cfg_cur_lvl = setting[i][11:0];
				REG_BIAS_CHANNEL:     cfg_bias_ch = setting[i][3:0];
				REG_BIAS_LEVEL:       cfg_bias_lvl = setting[i][11:0];
				default: ;
			endcase
		end
		cfg_write <= 1'b0;
	endtask

	// Offers one item, optionally after idle cycles, and records what it causes.
	task automatic send_word(input logic [15:0] w, input logic fe, input bit typed,
			input result_t typed_res);
		sample_t s;
		result_t r;
		bit      gives;
		s.sample_word = w;
		s.frame_end = fe;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (sample_stall);
		gives = guard_predict(s, r);
		if (typed)
			awaited_q.push_back(typed_res);
		else if (gives)
			awaited_q.push_back(r);
		items_sent++;
		if (fe)
			frames_sent++;
	endtask

	// Stops offering items and lets every pending result and item drain out.
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: check each accepted result, then pick the next stall.
	always @(posedge clk) begin : result_check
		result_t want;
		if (result_valid && !result_stall) begin
			if (awaited_q.size() == 0) begin
				report_fail($sformatf("Unexpected result %h", result));
			end else begin
				want = awaited_q.pop_front();
				if (result.dac_command !== want.dac_command ||
						result.tripped !== want.tripped ||
						result.trip_cause !== want.trip_cause) begin
					report_fail($sformatf(
						"Result mismatch: cmd %h/%h tripped %b/%b cause %0d/%0d (got/exp)",
						result.dac_command, want.dac_command, result.tripped,
						want.tripped, result.trip_cause, want.trip_cause));
				end
				n_results++;
				if (want.tripped)
					n_trips++;
			end
		end
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Watchdog expired with %0d results still awaited", awaited_q.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int       n, k, v, lvl;
		logic [3:0]  ch;
		logic [11:0] val;
		bit       fe, hot, loose;
		result_t  none;
		none = '0;

		// Model state after reset.
		cfg_sense_ch = 4'd0;
		cfg_sense_lvl = 13'd4100;
		cfg_trip_ch = 3'd2;
		cfg_trip_val = 12'd0;
		cfg_cur_ch = 4'd3;
		cfg_cur_lvl = 12'd60;
		cfg_bias_ch = 4'd2;
		cfg_bias_lvl = 12'd1420;
		foreach (ch_seen[i]) begin
			ch_seen[i] = 1'b0;
			ch_value[i] = '0;
		end
		viol_cnt = 0;
		send_idle_pct = 14;
		stall_pct = 82;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].word, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].res);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			// Idle pattern: slow receiver, then slow sender, then full rate.
			if (p < 2) begin
				send_idle_pct = 14;
				stall_pct = 82;
			end else if (p < 4) begin
				send_idle_pct = 82;
				stall_pct = 14;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end

			// Register settings: all zero, all one, otherwise random.
			if (p == 0) begin
				foreach (setting[i])
					setting[i] = '0;
			end else if (p == 2) begin
				foreach (setting[i])
					setting[i] = '1;
			end else begin
				foreach (setting[i])
					setting[i] = CFG_W'($urandom_range(0, 8191));
				if ($urandom_range(0, 3) != 0)
					setting[REG_SENSE_CHANNEL] = CFG_W'($urandom_range(0, NUM_CHANNELS - 1));
				if ($urandom_range(0, 3) != 0)
					setting[REG_CURRENT_CHANNEL] = CFG_W'($urandom_range(0, NUM_CHANNELS - 1));
				if ($urandom_range(0, 3) != 0)
					setting[REG_BIAS_CHANNEL] = CFG_W'($urandom_range(0, NUM_CHANNELS - 1));
				if ($urandom_range(0, 3) != 0)
					setting[REG_SENSE_LEVEL] = CFG_W'($urandom_range(0, 4095));
			end
			write_settings();

			// Frames of random length; most end cleanly on their last word,
			// some carry a forced hot value, a few have scattered frame ends.
			n = 0;
			while (n < PHASE_ITEMS) begin
				k = $urandom_range(1, 10);
				hot = ($urandom_range(0, 99) < 40);
				loose = ($urandom_range(0, 99) < 10);
				for (int j = 0; j < k; j++) begin
					case ($urandom_range(0, 7))
						0: ch = cfg_cur_ch;
						1: ch = cfg_bias_ch;
						2: ch = cfg_sense_ch;
						3: ch = 4'($urandom_range(0, 15));
						default: ch = 4'($urandom_range(0, NUM_CHANNELS - 1));
					endcase
					case ($urandom_range(0, 9))
						0: val = 12'h000;
						1: val = 12'hFFF;
						2, 3, 4: begin
							case ($urandom_range(0, 2))
								0: lvl = int'(cfg_cur_lvl);
								1: lvl = int'(cfg_bias_lvl);
								default: lvl = (cfg_sense_lvl > 4095) ? 4095 :
									int'(cfg_sense_lvl);
							endcase
							v = lvl + int'($urandom_range(0, 2)) - 1;
							if (v < 0)
								v = 0;
							if (v > 4095)
								v = 4095;
							val = 12'(v);
						end
						default: val = 12'($urandom_range(0, 4095));
					endcase
					if (hot && j == 0) begin
						case ($urandom_range(0, 2))
							0: ch = cfg_cur_ch;
							1: ch = cfg_bias_ch;
							default: ch = cfg_sense_ch;
						endcase
						val = 12'hFFF;
					end
					fe = loose ? ($urandom_range(0, 3) == 0) : (j == k - 1);
					send_word({ch, val}, fe, 1'b0, none);
					n++;
				end
			end
			drain_results();
		end

		$display("Sent %0d items in %0d frames over %0d register settings.",
			items_sent, frames_sent, PHASES + 1);
		$display("Checked %0d results, %0d of them trips; %0d failures.",
			n_results, n_trips, fail_cnt);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
